/* hdl/tksr_pkg.sv */
// shared types, codes and constants of the touch key serial reader
package tksr_pkg;

    localparam int unsigned KEY_BITS    = 16;
    localparam int unsigned KEY_NUM_W   = 5;
    localparam int unsigned BIT_POS_W   = 4;
    localparam int unsigned TIMER_W     = 16;
    localparam int unsigned APB_ADDR_W  = 5;
    localparam int unsigned APB_DATA_W  = 32;

    // request codes
    localparam logic [1:0] REQ_BLOCKING = 2'd1;
    localparam logic [1:0] REQ_POLLED   = 2'd2;

    // register indexes (byte address bits [4:2])
    localparam logic [2:0] REG_SIXTEEN_KEY_MODE    = 3'd0;
    localparam logic [2:0] REG_HALF_PERIOD_TICKS   = 3'd1;
    localparam logic [2:0] REG_VALID_TIMEOUT_TICKS = 3'd2;
    localparam logic [2:0] REG_VALID_SETTLE_TICKS  = 3'd3;
    localparam logic [2:0] REG_END_GAP_TICKS       = 3'd4;

    // register reset values
    localparam logic        RST_SIXTEEN_KEY_MODE    = 1'b0;
    localparam logic [7:0]  RST_HALF_PERIOD_TICKS   = 8'd2;
    localparam logic [15:0] RST_VALID_TIMEOUT_TICKS = 16'd50000;
    localparam logic [7:0]  RST_VALID_SETTLE_TICKS  = 8'd10;
    localparam logic [15:0] RST_END_GAP_TICKS       = 16'd2000;

    // key counts per mode
    localparam logic [KEY_NUM_W-1:0] NBITS_SIXTEEN = 5'd16;
    localparam logic [KEY_NUM_W-1:0] NBITS_EIGHT   = 5'd8;
    localparam logic [KEY_BITS-1:0]  MASK_SIXTEEN  = 16'hFFFF;
    localparam logic [KEY_BITS-1:0]  MASK_EIGHT    = 16'h00FF;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WAIT_LOW  = 3'd1,
        PH_WAIT_HIGH = 3'd2,
        PH_SETTLE    = 3'd3,
        PH_CLK_LOW   = 3'd4,
        PH_CLK_HIGH  = 3'd5,
        PH_GAP       = 3'd6
    } t_phase;

    typedef struct packed {
        logic        sixteen_key_mode;
        logic [7:0]  half_period_ticks;
        logic [15:0] valid_timeout_ticks;
        logic [7:0]  valid_settle_ticks;
        logic [15:0] end_gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic                 scl_level;
        logic                 busy_res;
        logic                 read_done;
        logic                 timed_out;
        logic [KEY_BITS-1:0]  key_mask;
        logic [KEY_NUM_W-1:0] key_number;
    } t_result;

    // highest set bit, 1-based, 0 when the mask is empty
    function automatic logic [KEY_NUM_W-1:0] highest_key(input logic [KEY_BITS-1:0] mask);
        logic [KEY_NUM_W-1:0] num;
        num = '0;
        for (int k = 0; k < KEY_BITS; k++) begin
            if (mask[k]) begin
                num = KEY_NUM_W'(k + 1);
            end
        end
        return num;
    endfunction

endpackage

/* hdl/tksr_cfg.sv */
// apb configuration registers of the touch key serial reader
module tksr_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tksr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tksr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tksr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output tksr_pkg::t_cfg                    o_cfg
);
    import tksr_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sixteen_key_mode    <= RST_SIXTEEN_KEY_MODE;
            r_cfg.half_period_ticks   <= RST_HALF_PERIOD_TICKS;
            r_cfg.valid_timeout_ticks <= RST_VALID_TIMEOUT_TICKS;
            r_cfg.valid_settle_ticks  <= RST_VALID_SETTLE_TICKS;
            r_cfg.end_gap_ticks       <= RST_END_GAP_TICKS;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SIXTEEN_KEY_MODE:    r_cfg.sixteen_key_mode    <= pwdata[0];
                REG_HALF_PERIOD_TICKS:   r_cfg.half_period_ticks   <= pwdata[7:0];
                REG_VALID_TIMEOUT_TICKS: r_cfg.valid_timeout_ticks <= pwdata[15:0];
                REG_VALID_SETTLE_TICKS:  r_cfg.valid_settle_ticks  <= pwdata[7:0];
                REG_END_GAP_TICKS:       r_cfg.end_gap_ticks       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SIXTEEN_KEY_MODE:    prdata = {31'd0, r_cfg.sixteen_key_mode};
            REG_HALF_PERIOD_TICKS:   prdata = {24'd0, r_cfg.half_period_ticks};
            REG_VALID_TIMEOUT_TICKS: prdata = {16'd0, r_cfg.valid_timeout_ticks};
            REG_VALID_SETTLE_TICKS:  prdata = {24'd0, r_cfg.valid_settle_ticks};
            REG_END_GAP_TICKS:       prdata = {16'd0, r_cfg.end_gap_ticks};
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/tksr_step.sv */
// per-tick read sequencer: phase state, timers, key sampling and held keys
module tksr_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_req_type,
    input  logic              i_sdo_level,
    input  tksr_pkg::t_cfg    i_cfg,
    output tksr_pkg::t_result o_res
);
    import tksr_pkg::*;

    t_phase               r_phase,  n_phase;
    logic [TIMER_W-1:0]   r_timer,  n_timer;
    logic [TIMER_W-1:0]   r_budget, n_budget;
    logic                 r_polled, n_polled;
    logic [BIT_POS_W-1:0] r_bit,    n_bit;
    logic [KEY_BITS-1:0]  r_wmask,  n_wmask;
    logic [KEY_BITS-1:0]  r_hmask,  n_hmask;
    logic [KEY_NUM_W-1:0] r_hnum,   n_hnum;

    logic                 done;
    logic                 tout;
    logic [TIMER_W-1:0]   budget_dec;
    logic [TIMER_W-1:0]   half_reload;
    logic [KEY_NUM_W-1:0] nbits;
    logic [KEY_NUM_W-1:0] bit_next;
    logic [KEY_BITS-1:0]  final_mask;

    assign budget_dec  = r_budget - 16'd1;
    assign half_reload = (i_cfg.half_period_ticks == 8'd0) ? '0
                       : {8'd0, i_cfg.half_period_ticks - 8'd1};
    assign nbits       = i_cfg.sixteen_key_mode ? NBITS_SIXTEEN : NBITS_EIGHT;
    assign bit_next    = {1'b0, r_bit} + 5'd1;
    assign final_mask  = r_wmask & (i_cfg.sixteen_key_mode ? MASK_SIXTEEN : MASK_EIGHT);

    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_budget = r_budget;
        n_polled = r_polled;
        n_bit    = r_bit;
        n_wmask  = r_wmask;
        n_hmask  = r_hmask;
        n_hnum   = r_hnum;
        done     = 1'b0;
        tout     = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_req_type == REQ_BLOCKING || i_req_type == REQ_POLLED) begin
                    n_polled = (i_req_type == REQ_POLLED);
                    n_budget = i_cfg.valid_timeout_ticks;
                    n_phase  = PH_WAIT_LOW;
                end
            end
            PH_WAIT_LOW, PH_WAIT_HIGH: begin
                if (i_sdo_level == (r_phase == PH_WAIT_HIGH)) begin
                    if (r_phase == PH_WAIT_LOW) begin
                        n_phase = PH_WAIT_HIGH;
                    end else begin
                        n_phase = PH_SETTLE;
                        n_timer = {8'd0, i_cfg.valid_settle_ticks};
                    end
                end else if (r_polled) begin
                    n_budget = budget_dec;
                    if (budget_dec == '0) begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                        tout    = 1'b1;
                    end
                end
            end
            PH_SETTLE: begin
                if (r_timer == '0) begin
                    n_phase = PH_CLK_LOW;
                    n_timer = half_reload;
                    n_bit   = '0;
                    n_wmask = '0;
                end else begin
                    n_timer = r_timer - 16'd1;
                end
            end
            PH_CLK_LOW: begin
                if (r_timer == '0) begin
                    // key bit is active low on the data line
                    if (!i_sdo_level) begin
                        n_wmask = r_wmask | (16'd1 << r_bit);
                    end
                    n_phase = PH_CLK_HIGH;
                    n_timer = half_reload;
                end else begin
                    n_timer = r_timer - 16'd1;
                end
            end
            PH_CLK_HIGH: begin
                if (r_timer == '0) begin
                    if (bit_next >= nbits) begin
                        n_phase = PH_GAP;
                        n_timer = i_cfg.end_gap_ticks;
                    end else begin
                        n_bit   = bit_next[BIT_POS_W-1:0];
                        n_phase = PH_CLK_LOW;
                        n_timer = half_reload;
                    end
                end else begin
                    n_timer = r_timer - 16'd1;
                end
            end
            PH_GAP: begin
                if (r_timer == '0) begin
                    n_hmask = final_mask;
                    n_hnum  = highest_key(final_mask);
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end else begin
                    n_timer = r_timer - 16'd1;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_timer  <= '0;
            r_budget <= '0;
            r_polled <= 1'b0;
            r_bit    <= '0;
            r_wmask  <= '0;
            r_hmask  <= '0;
            r_hnum   <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_budget <= n_budget;
            r_polled <= n_polled;
            r_bit    <= n_bit;
            r_wmask  <= n_wmask;
            r_hmask  <= n_hmask;
            r_hnum   <= n_hnum;
        end
    end

    always_comb begin
        o_res.scl_level  = (n_phase != PH_CLK_LOW);
        o_res.busy_res   = (n_phase != PH_IDLE);
        o_res.read_done  = done;
        o_res.timed_out  = tout;
        o_res.key_mask   = n_hmask;
        o_res.key_number = n_hnum;
    end

`ifndef SYNTH
    a_tout_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.timed_out |-> o_res.read_done)
        else $error("timeout without done pulse");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.read_done |-> !o_res.busy_res)
        else $error("done pulse while still busy");
    a_held_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hmask == '0) == (r_hnum == '0))
        else $error("held key number disagrees with held mask");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_phase) && $stable(r_timer))
        else $error("sequencer moved without an accepted tick");
`endif

endmodule

/* hdl/tksr_out_buf.sv */
// two-entry result buffer between the sequencer and the output channel
module tksr_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tksr_pkg::t_result i_res,
    output logic              o_can_push,
    output logic              o_valid,
    input  logic              i_ready,
    output tksr_pkg::t_result o_res
);
    import tksr_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_can_push = (r_count != 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign pop        = o_valid & i_ready;
    assign o_res      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer count out of range");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr))
        else $error("result buffer pointers disagree with count");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_can_push)
        else $error("push into a full result buffer");
`endif

endmodule

/* hdl/touch_key_serial_reader_core.sv */
// top level of the two-wire touch key serial reader
//
// channel | direction | handshake           | word
// --------+-----------+---------------------+-----------------------------------------
// tick    | in        | i_valid / o_ready   | i_req_type, i_sdo_level
// result  | out       | o_valid / i_ready   | o_scl_level, o_busy_res, o_read_done,
//         |           |                     | o_timed_out, o_key_mask, o_key_number
// config  | in        | apb psel / penable  | paddr, pwdata, prdata (5 registers)
//
// one tick word is taken every clock while o_ready is high; its result word is registered in the result buffer
// the sequencer state and the next-state logic form a single registered pass per tick
// a two-entry result buffer keeps o_ready high while one result waits on i_ready
// i_rst_n is synchronous: sequencer goes idle, keys clear, registers take reset values
// with the result side stalled twice, o_ready drops until a result word leaves
module touch_key_serial_reader_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tick words
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_req_type,
    input  logic                              i_sdo_level,
    // result words
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_scl_level,
    output logic                              o_busy_res,
    output logic                              o_read_done,
    output logic                              o_timed_out,
    output logic [tksr_pkg::KEY_BITS-1:0]     o_key_mask,
    output logic [tksr_pkg::KEY_NUM_W-1:0]    o_key_number,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tksr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tksr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tksr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import tksr_pkg::*;

    t_cfg    cfg;
    t_result step_res;
    t_result buf_res;
    logic    can_push;
    logic    tick_accept;

    // a tick is taken whenever the result buffer has a free slot
    assign o_ready     = can_push;
    assign tick_accept = i_valid & can_push;

    tksr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // phase sequencer: data-valid waits, settle, clock pulses, end gap
    tksr_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (tick_accept),
        .i_req_type  (i_req_type),
        .i_sdo_level (i_sdo_level),
        .i_cfg       (cfg),
        .o_res       (step_res)
    );

    // result words wait here for the downstream side
    tksr_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (tick_accept),
        .i_res      (step_res),
        .o_can_push (can_push),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (buf_res)
    );

    assign o_scl_level  = buf_res.scl_level;
    assign o_busy_res   = buf_res.busy_res;
    assign o_read_done  = buf_res.read_done;
    assign o_timed_out  = buf_res.timed_out;
    assign o_key_mask   = buf_res.key_mask;
    assign o_key_number = buf_res.key_number;

endmodule
